// File: rtl/uvst_pkg.sv
// ----------------------------------------------------------------------------
// uvst_pkg: shared definitions for the unique value set table
// Sizes, status codes, operation codes and the control word that the
// sequencer broadcasts to every storage cell of the chain.
// ----------------------------------------------------------------------------
`default_nettype none

package uvst_pkg;

	// table size and derived widths
	localparam int CAPACITY      = 16;
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int IDX_W         = $clog2(CAPACITY);
	localparam int VAL_W         = 32;

	// fixed field widths of the result word
	localparam int STATUS_W      = 3;
	localparam int ENTRY_COUNT_W = 5;
	localparam int ENTRY_INDEX_W = 4;

	// stream widths
	localparam int S_TDATA_W     = 32;
	localparam int S_TUSER_W     = 1;
	localparam int M_TDATA_W     = 48;
	localparam int M_TUSER_W     = 4;

	// operation codes
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	// command broadcast to all cells
	typedef enum logic [2:0] {
		CMD_HOLD,
		CMD_SRCH,
		CMD_APPEND,
		CMD_REMOVE,
		CMD_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic [VAL_W-1:0]   key;
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/uvst_cell.sv
// ----------------------------------------------------------------------------
// uvst_cell: one storage cell of the set chain
// Holds one value, compares it against the broadcast key, and takes its
// upper neighbor's value when closing a gap or rotating the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module uvst_cell
	import uvst_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire logic             occ,        // cell lies below the fill count
	input  wire logic             tail,       // cell is the first free slot
	input  wire logic             sh_in,      // a match sits at or below the lower neighbor
	input  wire logic [VAL_W-1:0] nbr_value,  // value of the upper neighbor
	output logic                  sh_out,
	output logic                  match_q,
	output logic [VAL_W-1:0]      value_q
);

	logic hit;

	// compare stored value against the key
	assign hit    = occ && (value_q == ctl.key);
	assign sh_out = sh_in | match_q;

	// latch compare result during search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmd == CMD_SRCH) begin
			match_q <= hit;
		end
	end

	// update stored value
	always_ff @(posedge clk) begin
		unique case (ctl.cmd)
			CMD_APPEND: begin
				if (tail) begin
					value_q <= ctl.key;
				end
			end
			CMD_REMOVE: begin
				if (sh_out) begin
					value_q <= nbr_value;
				end
			end
			CMD_ROTATE: begin
				value_q <= nbr_value;
			end
			CMD_HOLD, CMD_SRCH: begin
				value_q <= value_q;
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/unique_value_set_table.sv
// A word accepted on the input passes the search and update states into the listing state,
// where its first result word is registered on the output. The input takes no new word until the
// listing has made a full turn of the cell ring; an item that leaves the table empty lists a
// single word, and output stalls hold the listing back.
// Reset: arst_n clears the fill count, sequencer and output valid, not the stored values.
// ----------------------------------------------------------------------------
// unique_value_set_table: insertion-ordered set with compaction
// A chain of storage cells keeps up to CAPACITY distinct values in insertion
// order. Each input word adds or removes one value, then the whole table is
// listed as a run of result words by rotating the ring once.
// ----------------------------------------------------------------------------
`default_nettype none

module unique_value_set_table
	import uvst_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
	input  wire logic [S_TUSER_W-1:0] s_tuser,   // [0] operation
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,   // [4:0] entry_count, [8:5] entry_index,
	                                             // [40:9] entry_value, [47:41] zero
	output logic [M_TUSER_W-1:0]      m_tuser,   // [2:0] status, [3] entry_valid
	output logic                      m_tlast    // last
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SRCH = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_LIST = 2'd3;

	logic [1:0]               state_q;
	logic                     op_q;
	logic [VAL_W-1:0]         key_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         idx_q;
	logic [STATUS_W-1:0]      status_q;

	cell_ctl_t                ctl;
	logic [CAPACITY-1:0]      occ;
	logic [CAPACITY-1:0]      tail;
	logic [CAPACITY-1:0]      match_vec;
	logic [CAPACITY:0]        sh;
	logic [VAL_W-1:0]         cell_value [CAPACITY];

	logic                     hit;
	logic                     full;
	logic                     out_free;
	logic                     emit;
	logic                     list_go;
	logic                     is_last;
	logic [STATUS_W-1:0]      upd_status;
	cell_cmd_t                upd_cmd;

	logic [STATUS_W-1:0]      o_status_q;
	logic [CNT_W-1:0]         o_count_q;
	logic [IDX_W-1:0]         o_index_q;
	logic [VAL_W-1:0]         o_value_q;
	logic                     o_evalid_q;
	logic                     o_last_q;
	logic                     m_tvalid_q;

	assign s_tready = (state_q == S_IDLE);

	// per-cell occupancy and tail flags
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_flag
			assign occ[i]  = (CNT_W'(i) < count_q);
			assign tail[i] = (CNT_W'(i) == count_q);
		end
	endgenerate

	// chain of cells, ring closed from the top cell back to cell 0
	assign sh[0] = 1'b0;
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			uvst_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.occ       (occ[i]),
				.tail      (tail[i]),
				.sh_in     (sh[i]),
				.nbr_value (cell_value[(i + 1) % CAPACITY]),
				.sh_out    (sh[i+1]),
				.match_q   (match_vec[i]),
				.value_q   (cell_value[i])
			);
		end
	endgenerate

	// decide the operation outcome
	assign hit  = |match_vec;
	assign full = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		upd_status = ST_NOT_FOUND;
		upd_cmd    = CMD_HOLD;
		if (op_q == OP_ADD) begin
			if (hit) begin
				upd_status = ST_PRESENT;
			end else if (full) begin
				upd_status = ST_FULL;
			end else begin
				upd_status = ST_ADDED;
				upd_cmd    = CMD_APPEND;
			end
		end else begin
			if (hit) begin
				upd_status = ST_REMOVED;
				upd_cmd    = CMD_REMOVE;
			end
		end
	end

	// listing step control
	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = (count_q == '0) || (CNT_W'(idx_q) < count_q);
	assign list_go  = (state_q == S_LIST) && (!emit || out_free);
	assign is_last  = (CNT_W'(idx_q) == (count_q - 1'b1));

	// broadcast command to the chain
	always_comb begin
		ctl.key = key_q;
		ctl.cmd = CMD_HOLD;
		unique case (state_q)
			S_SRCH: ctl.cmd = CMD_SRCH;
			S_UPD:  ctl.cmd = upd_cmd;
			S_LIST: begin
				if (list_go && (count_q != '0)) begin
					ctl.cmd = CMD_ROTATE;
				end
			end
			default: ctl.cmd = CMD_HOLD;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			status_q <= ST_ADDED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					status_q <= upd_status;
					idx_q    <= '0;
					state_q  <= S_LIST;
					if (upd_cmd == CMD_APPEND) begin
						count_q <= count_q + 1'b1;
					end else if (upd_cmd == CMD_REMOVE) begin
						count_q <= count_q - 1'b1;
					end
				end
				S_LIST: begin
					if (list_go) begin
						if ((count_q == '0) || (idx_q == IDX_W'(CAPACITY - 1))) begin
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= s_tuser[0];
			key_q <= s_tdata[VAL_W-1:0];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (list_go && emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (list_go && emit) begin
			o_status_q <= status_q;
			o_count_q  <= count_q;
			if (count_q == '0) begin
				o_index_q  <= '0;
				o_value_q  <= '0;
				o_evalid_q <= 1'b0;
				o_last_q   <= 1'b1;
			end else begin
				o_index_q  <= idx_q;
				o_value_q  <= cell_value[0];
				o_evalid_q <= 1'b1;
				o_last_q   <= is_last;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, o_value_q, ENTRY_INDEX_W'(o_index_q),
	                   ENTRY_COUNT_W'(o_count_q)};
	assign m_tuser  = {o_evalid_q, o_status_q};
	assign m_tlast  = o_last_q;

endmodule

`default_nettype wire

// File: rtl/uvst_checker.sv
// ----------------------------------------------------------------------------
// uvst_checker: port-level checks for the unique value set table
// Watches the stream ports and flags stalls that lose data, runs that break
// their framing, and an input side that is still ready right after an accept.
// ----------------------------------------------------------------------------
`default_nettype none

module uvst_checker
	import uvst_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser,
	input wire logic                 m_tlast
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("result word changed under stall");

	// one word at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in work");

	// empty-table word is alone in its run and shows zero count
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[3] |-> m_tlast && (m_tdata[4:0] == 5'd0))
		else $error("malformed empty-table word");

	// listed index stays below the count
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> ({1'b0, m_tdata[8:5]} < m_tdata[4:0]))
		else $error("entry index beyond entry count");

	// last word of a run carries index count minus one
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] && m_tlast |-> ({1'b0, m_tdata[8:5]} + 5'd1 == m_tdata[4:0]))
		else $error("run ends at the wrong index");

endmodule

bind unique_value_set_table uvst_checker u_uvst_checker (.*);

`default_nettype wire
